// ===== src/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Shared constants, codes and types for the heap datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned DefKeyWidth = 32;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_BAD_POS  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_DN_WAITR,
    ST_TOP_RD,
    ST_TOP_WAIT,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== src/mhpq_store.sv =====
// ----------------------------------------------------------------------------
// Heap key store
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_store
  import mhpq_pkg::*;
#(
  parameter int unsigned Capacity = DefCapacity,
  parameter int unsigned KeyWidth = DefKeyWidth,
  localparam int unsigned AW = $clog2(Capacity)
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire logic [KeyWidth-1:0] wdata_i,
  input  wire logic [AW-1:0]       raddr_i,
  output      logic [KeyWidth-1:0] rdata_o
);

  logic [KeyWidth-1:0] mem [Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/min_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue
// Binary min-heap of signed keys in one synchronous memory.
//
// Channel   Direction  Handshake         Payload
// request   in         start_i, busy_o   kind_i, key_i, position_i
// result    out        done_o            top_key_o, entry_count_o, is_empty_o,
//                                        status_o
//
// A push writes the key at the end and sifts it up, comparing it with its
// parent at each level; a pop moves the last entry to the root and sifts it
// down, comparing it with both children at each level. An update rises like
// a push or, if it does not rise, falls like a pop. A refused request or a
// no-op only reads the root. The root is read back from entry zero each time.
// Reset clears the count; memory contents need no clearing.
// Results are shown for one cycle with done_o and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int unsigned Capacity = DefCapacity,
  parameter int unsigned KeyWidth = DefKeyWidth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output      logic        busy_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] key_i,
  input  wire logic [5:0]  position_i,
  output      logic        done_o,
  output      logic [31:0] top_key_o,
  output      logic [6:0]  entry_count_o,
  output      logic        is_empty_o,
  output      logic [1:0]  status_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);

  state_e state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [KeyWidth-1:0] cur_q, cur_d;
  logic [KeyWidth-1:0] lk_q, lk_d;
  logic [KeyWidth-1:0] top_q, top_d;
  logic [1:0]          stat_q, stat_d;
  logic                upd_q, upd_d;
  logic                moved_q, moved_d;
  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [KeyWidth-1:0] wdata, rdata;

  logic [KeyWidth-1:0] key_in;
  logic [CW:0]         l_ext, r_ext;
  logic [AW-1:0]       par;
  logic                has_l, has_r, l_lt, r_lt, r_lt_l;

  assign key_in = KeyWidth'(key_i);
  assign par    = AW'((idx_q - AW'(1)) >> 1);
  assign l_ext  = (CW + 1)'({idx_q, 1'b1});
  assign r_ext  = l_ext + (CW + 1)'(1);
  assign has_l  = l_ext < {1'b0, cnt_q};
  assign has_r  = r_ext < {1'b0, cnt_q};
  assign l_lt   = $signed(lk_q) < $signed(cur_q);
  assign r_lt   = $signed(rdata) < $signed(cur_q);
  assign r_lt_l = $signed(rdata) < $signed(lk_q);

  mhpq_store #(.Capacity(Capacity), .KeyWidth(KeyWidth)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      stat_q  <= STAT_OK;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      stat_q  <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    cur_q   <= cur_d;
    lk_q    <= lk_d;
    top_q   <= top_d;
    upd_q   <= upd_d;
    moved_q <= moved_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    lk_d    = lk_q;
    top_d   = top_q;
    stat_d  = stat_q;
    upd_d   = upd_q;
    moved_d = moved_q;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = cur_q;
    raddr   = par;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          stat_d  = STAT_OK;
          cur_d   = key_in;
          moved_d = 1'b0;
          upd_d   = 1'b0;
          unique case (kind_e'(kind_i))
            KIND_PUSH: begin
              if (cnt_q >= CW'(Capacity)) begin
                stat_d  = STAT_FULL;
                state_d = ST_TOP_RD;
              end else begin
                we      = 1'b1;
                waddr   = AW'(cnt_q);
                wdata   = key_in;
                idx_d   = AW'(cnt_q);
                cnt_d   = cnt_q + CW'(1);
                state_d = ST_UP_RD;
              end
            end
            KIND_POP: begin
              if (cnt_q == '0) begin
                stat_d  = STAT_EMPTY;
                state_d = ST_TOP_RD;
              end else begin
                cnt_d   = cnt_q - CW'(1);
                raddr   = AW'(cnt_q - CW'(1));
                idx_d   = '0;
                state_d = ST_DN_RDL;
                upd_d   = 1'b1;
              end
            end
            KIND_UPDATE: begin
              if (32'(position_i) >= 32'(cnt_q)) begin
                stat_d  = STAT_BAD_POS;
                state_d = ST_TOP_RD;
              end else begin
                we      = 1'b1;
                waddr   = AW'(position_i);
                wdata   = key_in;
                idx_d   = AW'(position_i);
                upd_d   = 1'b1;
                state_d = ST_UP_RD;
              end
            end
            default: state_d = ST_TOP_RD;
          endcase
          if (kind_e'(kind_i) == KIND_POP && cnt_q != '0) begin
            upd_d = 1'b0;
          end
        end
      end
      ST_UP_RD: begin
        raddr = par;
        if (idx_q == '0) begin
          we      = 1'b1;
          wdata   = cur_q;
          state_d = (upd_q && !moved_q) ? ST_DN_RDL : ST_TOP_RD;
          raddr   = AW'(l_ext);
        end else begin
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if ($signed(rdata) > $signed(cur_q)) begin
          we      = 1'b1;
          waddr   = idx_q;
          wdata   = rdata;
          idx_d   = par;
          moved_d = 1'b1;
          state_d = ST_UP_RD;
        end else begin
          we      = 1'b1;
          wdata   = cur_q;
          state_d = (upd_q && !moved_q) ? ST_DN_RDL : ST_TOP_RD;
        end
        if (state_d == ST_UP_RD) begin
          raddr = AW'((par - AW'(1)) >> 1);
        end
      end
      ST_DN_RDL: begin
        if (!upd_q && idx_q == '0 && !moved_q) begin
          cur_d   = rdata;
          moved_d = 1'b1;
        end
        raddr   = AW'(l_ext);
        state_d = ST_DN_RDR;
      end
      ST_DN_RDR: begin
        lk_d    = rdata;
        raddr   = AW'(r_ext);
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (has_l && has_r && r_lt && r_lt_l || has_l && has_r && r_lt && !l_lt) begin
          we      = 1'b1;
          wdata   = rdata;
          idx_d   = AW'(r_ext);
          state_d = ST_DN_RDL;
        end else if (has_l && l_lt) begin
          we      = 1'b1;
          wdata   = lk_q;
          idx_d   = AW'(l_ext);
          state_d = ST_DN_RDL;
        end else begin
          we      = 1'b1;
          wdata   = cur_q;
          state_d = ST_TOP_RD;
        end
        moved_d = 1'b1;
        upd_d   = 1'b0;
      end
      ST_TOP_RD: begin
        raddr   = '0;
        state_d = ST_TOP_WAIT;
      end
      ST_TOP_WAIT: begin
        top_d   = (cnt_q == '0) ? '0 : rdata;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = (state_q == ST_DONE);
  assign top_key_o     = 32'($signed(top_q));
  assign entry_count_o = 7'(cnt_q);
  assign is_empty_o    = (cnt_q == '0);
  assign status_o      = stat_q;

endmodule

`default_nettype wire

// ===== src/mhpq_checker.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue checker
// Port-level properties of the request and result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_checker
  import mhpq_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [6:0]  entry_count_o,
  input wire logic        is_empty_o,
  input wire logic [1:0]  status_o,
  input wire logic [31:0] top_key_o
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result outside a request");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("request not taken");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_empty_o == (entry_count_o == 7'd0)))
    else $error("empty flag mismatch");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |-> (top_key_o == 32'd0)) else $error("empty top");

  a_fail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_OK) |-> $stable(entry_count_o))
    else $error("count changed on a refused request");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .entry_count_o(entry_count_o),
  .is_empty_o   (is_empty_o),
  .status_o     (status_o),
  .top_key_o    (top_key_o)
);

`default_nettype wire
